// ----- rtl/dxt_block_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// dxt_block_decoder_core_assert.svh
// Assertion macros used by the block decoder core.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_CORE_ASSERT_SVH
`define DXT_BLOCK_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define DXT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define DXT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dxt_pkg.sv -----
// ----------------------------------------------------------------------------
// dxt_pkg
// Types and constants for the S3TC block decoder and its shared
// interpolation unit.
// ----------------------------------------------------------------------------
package dxt_pkg;

    // Format register codes
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    // Register index of the format register
    localparam logic CFG_FORMAT = 1'b0;

    // Interpolation unit widths
    localparam int OP_W        = 4;   // op tag, 12 ops
    localparam int SUM_W       = 11;  // weighted sum, at most 1788
    localparam int RECIP_W     = 15;  // reciprocal, up to 2^14
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Reciprocals scaled by 2^14, exact for every sum the ops produce
    localparam logic [RECIP_W-1:0] RECIP_1 = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP_2 = 15'd8192;
    localparam logic [RECIP_W-1:0] RECIP_3 = 15'd5462;
    localparam logic [RECIP_W-1:0] RECIP_5 = 15'd3277;
    localparam logic [RECIP_W-1:0] RECIP_7 = 15'd2341;

    // Op sequence: colour 2 (rgb), colour 3 (rgb), alpha ramp entries 2..7
    localparam logic [OP_W-1:0] OP_PAL3_BASE = 4'd3;
    localparam logic [OP_W-1:0] OP_RAMP_BASE = 4'd6;
    localparam logic [OP_W-1:0] OP_LAST      = 4'd11;
    localparam logic [OP_W-1:0] OP_DONE      = 4'd12;

    localparam logic [3:0] TEXEL_LAST = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // Request into the interpolation unit: (wa*x + wb*y + rnd) / d
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    tag;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [2:0]         wa;
        logic [2:0]         wb;
        logic [7:0]         rnd;
        logic [RECIP_W-1:0] recip;
    } t_interp_req;

    // Result back from the interpolation unit
    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] tag;
        logic [7:0]      value;
    } t_interp_res;

endpackage

// ----- rtl/dxt_interp.sv -----
// ----------------------------------------------------------------------------
// dxt_interp
// Shared interpolation unit: weighted sum of two 8-bit values plus rounding
// term, registered, then divided by a small constant through a reciprocal
// multiply. One op may enter each cycle; its result appears in the following cycle.
// ----------------------------------------------------------------------------
module dxt_interp
    import dxt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_interp_req i_req,
    output t_interp_res o_res
);

    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [RECIP_W-1:0] r_recip;
    logic [OP_W-1:0]    r_tag;
    logic               r_valid;
    logic [PROD_W-1:0]  w_prod;

    // Weighted sum, small weights only
    assign n_sum = SUM_W'(i_req.wa) * SUM_W'(i_req.x)
                 + SUM_W'(i_req.wb) * SUM_W'(i_req.y)
                 + SUM_W'(i_req.rnd);

    // First stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
        r_sum   <= n_sum;
        r_recip <= i_req.recip;
        r_tag   <= i_req.tag;
    end

    // Division by reciprocal; the caller registers the result
    assign w_prod = PROD_W'(r_sum) * PROD_W'(r_recip);

    assign o_res.valid = r_valid;
    assign o_res.tag   = r_tag;
    assign o_res.value = w_prod[RECIP_SHIFT +: 8];

endmodule

// ----- rtl/dxt_block_decoder_core.sv -----
// ----------------------------------------------------------------------------
// dxt_block_decoder_core
// S3TC block decoder (DXT1, DXT3, DXT5): 64-bit block words in, sixteen
// RGBA texels per colour word out in row-major order.
//
// Input stream s_axis carries one block word per item, block byte k in
// bits 8k+7..8k. In DXT3 and DXT5 an alpha word precedes each colour word;
// it is stored and yields no texels. Output stream m_axis carries one texel
// per item, tlast set on the sixteenth texel of a block.
// The format register sits at APB address 0; writing it also makes the next
// DXT3/DXT5 word an alpha word.
// Operation: an alpha word is stored while the sequencer stays idle. For a
// colour word the shared interpolation unit works out the 12 derived
// palette and alpha ramp entries one per cycle, then the sixteen texels
// are emitted, one per cycle while m_axis_tready allows. s_axis_tready is
// high only while the sequencer is idle, so a new word is taken only after
// the last texel of the previous colour word has been loaded.
// When m_axis_tready is low the texel in the output register holds and the
// sequencer waits. Reset clears the format (DXT1), the stored alpha word
// and the alpha/colour phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_core_assert.svh"

module dxt_block_decoder_core
    import dxt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Block word input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] block_word
    // Texel output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] alpha, [35:32] texel_index, pad
    output logic        m_axis_tlast    // last_texel
);

    // ------------------------------------------------------------------
    // Helpers: 565 expansion by bit replication
    // ------------------------------------------------------------------
    function automatic logic [7:0] chan_of(input logic [15:0] c, input logic [1:0] ch);
        logic [7:0] v;
        case (ch)
            2'd0:    v = {c[15:11], c[15:13]};
            2'd1:    v = {c[10:5], c[10:9]};
            default: v = {c[4:0], c[4:2]};
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_state       r_state;
    t_state       n_state;
    logic [1:0]   r_fmt;
    logic         r_expect;
    logic [63:0]  r_alpha;
    logic [63:0]  r_word;
    logic         r_four;
    logic [OP_W-1:0] r_op;
    logic [3:0]   r_texel;
    logic [7:0]   r_pal2 [3];
    logic [7:0]   r_pal3 [3];
    logic [7:0]   r_ramp [6];

    logic         r_out_valid;
    logic [39:0]  r_out_data;
    logic         r_out_last;

    logic         w_cfg_wr;
    logic         w_acc;
    logic         w_is_alpha;
    logic         w_is_colour;
    logic         w_ready;
    logic         w_issue;
    logic         w_load;

    t_interp_req  w_req;
    t_interp_res  w_res;

    logic [1:0]   w_ch;
    logic [2:0]   w_step;

    logic [31:0]  w_cbits;
    logic [47:0]  w_abits;
    logic [1:0]   w_cidx;
    logic [3:0]   w_nib;
    logic [5:0]   w_aoff;
    logic [2:0]   w_acode;
    logic [7:0]   w_red;
    logic [7:0]   w_green;
    logic [7:0]   w_blue;
    logic [7:0]   w_a;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_FORMAT);
    assign prdata   = (paddr[2] == CFG_FORMAT) ? {30'd0, r_fmt} : 32'd0;

    // ------------------------------------------------------------------
    // Input item classification
    // ------------------------------------------------------------------
    assign w_acc       = s_axis_tvalid && s_axis_tready;
    assign w_is_alpha  = ((r_fmt == FMT_DXT3) || (r_fmt == FMT_DXT5)) && !r_expect;
    assign w_is_colour = (r_fmt == FMT_DXT1)
                      || (((r_fmt == FMT_DXT3) || (r_fmt == FMT_DXT5)) && r_expect);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_is_colour) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_op == OP_DONE) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load && (r_texel == TEXEL_LAST)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        w_ready = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: w_ready = 1'b1;
            ST_CALC: w_issue = (r_op <= OP_LAST);
            ST_EMIT: w_load  = !r_out_valid || m_axis_tready;
            default: w_ready = 1'b0;
        endcase
    end

    assign s_axis_tready = w_ready;

    // ------------------------------------------------------------------
    // Control and block state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fmt    <= FMT_DXT1;
            r_expect <= 1'b0;
            r_alpha  <= 64'd0;
            r_op     <= '0;
            r_texel  <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_fmt    <= pwdata[1:0];
                r_expect <= 1'b0;
            end else if (w_acc && w_is_alpha) begin
                r_alpha  <= s_axis_tdata;
                r_expect <= 1'b1;
            end else if (w_acc && w_is_colour) begin
                r_expect <= 1'b0;
            end
            // op counter runs through the issue slots, then OP_DONE while the last result drains
            if (r_state == ST_CALC) r_op <= r_op + 1'b1;
            else                    r_op <= '0;
            // texel counter
            if (r_state != ST_EMIT) r_texel <= '0;
            else if (w_load)        r_texel <= r_texel + 1'b1;
        end
    end

    // Colour word and palette mode
    always_ff @(posedge i_clk) begin
        if (w_acc && w_is_colour) begin
            r_word <= s_axis_tdata;
            r_four <= (r_fmt != FMT_DXT1) || (s_axis_tdata[15:0] > s_axis_tdata[31:16]);
        end
    end

    // ------------------------------------------------------------------
    // Op decode for the shared interpolation unit
    // ------------------------------------------------------------------
    always_comb begin
        w_req       = '0;
        w_req.valid = w_issue;
        w_req.tag   = r_op;
        w_ch        = 2'd0;
        w_step      = 3'd0;
        if (r_op < OP_PAL3_BASE) begin
            // colour 2
            w_ch    = r_op[1:0];
            w_req.x = chan_of(r_word[15:0], w_ch);
            w_req.y = chan_of(r_word[31:16], w_ch);
            if (r_four) begin
                w_req.wa = 3'd2; w_req.wb = 3'd1; w_req.rnd = 8'd1; w_req.recip = RECIP_3;
            end else begin
                w_req.wa = 3'd1; w_req.wb = 3'd1; w_req.rnd = 8'd0; w_req.recip = RECIP_2;
            end
        end else if (r_op < OP_RAMP_BASE) begin
            // colour 3; transparent black in three-colour mode
            w_ch    = 2'(r_op - OP_PAL3_BASE);
            w_req.x = chan_of(r_word[15:0], w_ch);
            w_req.y = chan_of(r_word[31:16], w_ch);
            if (r_four) begin
                w_req.wa = 3'd1; w_req.wb = 3'd2; w_req.rnd = 8'd1; w_req.recip = RECIP_3;
            end else begin
                w_req.wa = 3'd0; w_req.wb = 3'd0; w_req.rnd = 8'd0; w_req.recip = RECIP_1;
            end
        end else begin
            // alpha ramp entry step+1, step from 1 to 6
            w_step  = 3'(r_op - OP_RAMP_BASE + 4'd1);
            w_req.x = r_alpha[7:0];
            w_req.y = r_alpha[15:8];
            if (r_alpha[7:0] > r_alpha[15:8]) begin
                w_req.wa = 3'(3'd7 - w_step); w_req.wb = w_step;
                w_req.rnd = 8'd3; w_req.recip = RECIP_7;
            end else if (w_step <= 3'd4) begin
                w_req.wa = 3'(3'd5 - w_step); w_req.wb = w_step;
                w_req.rnd = 8'd2; w_req.recip = RECIP_5;
            end else if (w_step == 3'd5) begin
                // fixed zero
                w_req.wa = 3'd0; w_req.wb = 3'd0; w_req.rnd = 8'd0; w_req.recip = RECIP_1;
            end else begin
                // fixed full opacity
                w_req.wa = 3'd0; w_req.wb = 3'd0; w_req.rnd = 8'd255; w_req.recip = RECIP_1;
            end
        end
    end

    dxt_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // Write-back of interpolated entries
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            if (w_res.tag < OP_PAL3_BASE) begin
                r_pal2[w_res.tag[1:0]] <= w_res.value;
            end else if (w_res.tag < OP_RAMP_BASE) begin
                r_pal3[2'(w_res.tag - OP_PAL3_BASE)] <= w_res.value;
            end else begin
                r_ramp[3'(w_res.tag - OP_RAMP_BASE)] <= w_res.value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Texel assembly
    // ------------------------------------------------------------------
    assign w_cbits = r_word[63:32];
    assign w_abits = r_alpha[63:16];
    assign w_cidx  = w_cbits[{r_texel, 1'b0} +: 2];
    assign w_nib   = r_alpha[{r_texel, 2'b00} +: 4];
    assign w_aoff  = {1'b0, r_texel, 1'b0} + {2'b00, r_texel};
    assign w_acode = w_abits[w_aoff +: 3];

    always_comb begin
        case (w_cidx)
            2'd0: begin
                w_red   = chan_of(r_word[15:0], 2'd0);
                w_green = chan_of(r_word[15:0], 2'd1);
                w_blue  = chan_of(r_word[15:0], 2'd2);
            end
            2'd1: begin
                w_red   = chan_of(r_word[31:16], 2'd0);
                w_green = chan_of(r_word[31:16], 2'd1);
                w_blue  = chan_of(r_word[31:16], 2'd2);
            end
            2'd2: begin
                w_red   = r_pal2[0];
                w_green = r_pal2[1];
                w_blue  = r_pal2[2];
            end
            default: begin
                w_red   = r_pal3[0];
                w_green = r_pal3[1];
                w_blue  = r_pal3[2];
            end
        endcase
    end

    // Alpha per format
    always_comb begin
        case (r_fmt)
            FMT_DXT3: w_a = {w_nib, w_nib};
            FMT_DXT5: begin
                if (w_acode == 3'd0)      w_a = r_alpha[7:0];
                else if (w_acode == 3'd1) w_a = r_alpha[15:8];
                else                      w_a = r_ramp[3'(w_acode - 3'd2)];
            end
            default:  w_a = ((w_cidx == 2'd3) && !r_four) ? 8'd0 : 8'd255;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_data <= {4'd0, r_texel, w_a, w_blue, w_green, w_red};
            r_out_last <= (r_texel == TEXEL_LAST);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DXT_ASSERT_NEXT(a_colour_starts_calc, w_acc && w_is_colour, r_state == ST_CALC, "colour word did not start palette build")
    `DXT_ASSERT_NEXT(a_alpha_sets_phase, w_acc && w_is_alpha, r_expect && (r_state == ST_IDLE), "alpha word did not set colour phase")
    `DXT_ASSERT_IMPL(a_wb_in_calc, w_res.valid, r_state == ST_CALC, "interpolation result outside palette build")
    `DXT_ASSERT_IMPL(a_last_index, r_out_valid && r_out_last, r_out_data[35:32] == TEXEL_LAST, "tlast on a texel other than the sixteenth")

endmodule

// ----- tb/dxt_block_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// dxt_block_decoder_core_tb
// Self-checking bench for the S3TC block decoder. Block words go in on the
// input stream, and a local decoder predicts the sixteen texels of every
// colour word. Each texel leaving the output stream is checked against the
// oldest prediction. Directed tests cover the palette modes, the DXT3
// nibbles, both DXT5 ramps, the alpha/colour phase restart on a format
// write and the unused format code. A random stream then runs through the
// three defined formats with random gaps on both sides, none in a calm phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dxt_block_decoder_core_tb;
    import dxt_pkg::*;

    // Format code with no defined decode: words are dropped
    localparam logic [1:0] FMT_NONE = 2'd3;
    // Cycles for the block to finish a word that gives no texel
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] pos;
        logic       last_texel;
    } t_texel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // [63:0] block_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] alpha, [35:32] texel_index, pad
    logic        m_axis_tlast;          // last_texel

    // Local copy of the decoder state
    logic [1:0]  cur_fmt = FMT_DXT1;
    logic [63:0] held_alpha_word = '0;
    bit          want_colour = 1'b0;

    t_texel texel_q [$];
    int     mismatches = 0;
    bit     calm = 1'b0;
    int     rx_hold = 0;
    t_texel want_t;
    t_texel got_t;

    dxt_block_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Mostly short gaps, now and then a long one; none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 8)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Predict the texels of one accepted block word
    task automatic decode_block(input logic [63:0] w);
        int          pal [4][4];
        int          ramp [8];
        int          a0;
        int          a1;
        int          sel;
        int          alpha;
        logic [15:0] c0;
        logic [15:0] c1;
        t_texel      t;
        if (cur_fmt == FMT_NONE)
            return;
        // DXT3/DXT5: the first word of a pair is only stored
        if (cur_fmt != FMT_DXT1 && !want_colour) begin
            held_alpha_word = w;
            want_colour = 1'b1;
            return;
        end
        want_colour = 1'b0;

        // Endpoints, 565 widened by bit replication
        c0 = w[15:0];
        c1 = w[31:16];
        pal[0][0] = int'({c0[15:11], c0[15:13]});
        pal[0][1] = int'({c0[10:5], c0[10:9]});
        pal[0][2] = int'({c0[4:0], c0[4:2]});
        pal[1][0] = int'({c1[15:11], c1[15:13]});
        pal[1][1] = int'({c1[10:5], c1[10:9]});
        pal[1][2] = int'({c1[4:0], c1[4:2]});
        pal[0][3] = 255;
        pal[1][3] = 255;
        if (cur_fmt != FMT_DXT1 || c0 > c1) begin
            for (int k = 0; k < 3; k++) begin
                pal[2][k] = (2 * pal[0][k] + pal[1][k] + 1) / 3;
                pal[3][k] = (pal[0][k] + 2 * pal[1][k] + 1) / 3;
            end
            pal[3][3] = 255;
        end else begin
            // three-colour mode, index 3 is transparent black
            for (int k = 0; k < 3; k++) begin
                pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
                pal[3][k] = 0;
            end
            pal[3][3] = 0;
        end
        pal[2][3] = 255;

        // DXT5 alpha ramp, 8 entries or 6 plus 0 and 255
        a0 = int'(held_alpha_word[7:0]);
        a1 = int'(held_alpha_word[15:8]);
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1) begin
            for (int i = 1; i <= 6; i++)
                ramp[i + 1] = ((7 - i) * a0 + i * a1 + 3) / 7;
        end else begin
            for (int i = 1; i <= 4; i++)
                ramp[i + 1] = ((5 - i) * a0 + i * a1 + 2) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
        end

        for (int i = 0; i < 16; i++) begin
            sel = int'(w[32 + 2 * i +: 2]);
            alpha = pal[sel][3];
            if (cur_fmt == FMT_DXT3)
                alpha = int'(held_alpha_word[4 * i +: 4]) * 17;
            else if (cur_fmt == FMT_DXT5)
                alpha = ramp[held_alpha_word[16 + 3 * i +: 3]];
            t.red = 8'(pal[sel][0]);
            t.green = 8'(pal[sel][1]);
            t.blue = 8'(pal[sel][2]);
            t.alpha = 8'(alpha);
            t.pos = 4'(i);
            t.last_texel = (i == 15);
            texel_q.push_back(t);
        end
    endtask

    // Send one block word, predicting on acceptance
    task automatic send_word(input logic [63:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        decode_block(w);
    endtask

    // Stop sending, wait for all texels, then let the block go idle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (texel_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the format register; also restarts the alpha/colour phase
    task automatic write_format(input logic [1:0] fmt);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {CFG_FORMAT, 2'b00};
        pwdata <= 32'(fmt);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_fmt = fmt;
        want_colour = 1'b0;
    endtask

    // Random word, with equal endpoints now and then
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w[31:16] = w[15:0];
            1: w[15:8] = w[7:0];
            default: ;
        endcase
        return w;
    endfunction

    // Texel checker and output-side stall generator
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = pick_gap();
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_t.red = m_axis_tdata[7:0];
            got_t.green = m_axis_tdata[15:8];
            got_t.blue = m_axis_tdata[23:16];
            got_t.alpha = m_axis_tdata[31:24];
            got_t.pos = m_axis_tdata[35:32];
            got_t.last_texel = m_axis_tlast;
            if (texel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected texel: r=%h g=%h b=%h a=%h pos=%0d last=%0b",
                             got_t.red, got_t.green, got_t.blue, got_t.alpha,
                             got_t.pos, got_t.last_texel);
            end else begin
                want_t = texel_q.pop_front();
                if (got_t.red !== want_t.red || got_t.green !== want_t.green ||
                    got_t.blue !== want_t.blue || got_t.alpha !== want_t.alpha ||
                    got_t.pos !== want_t.pos ||
                    got_t.last_texel !== want_t.last_texel) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("texel differs: exp r=%h g=%h b=%h a=%h pos=%0d last=%0b, got r=%h g=%h b=%h a=%h pos=%0d last=%0b",
                                 want_t.red, want_t.green, want_t.blue, want_t.alpha,
                                 want_t.pos, want_t.last_texel,
                                 got_t.red, got_t.green, got_t.blue, got_t.alpha,
                                 got_t.pos, got_t.last_texel);
                end
            end
        end
    end

    // DXT1 from reset: four-colour, three-colour, equal endpoints, extremes
    task automatic test_dxt1_palettes();
        send_word(64'hE4E4E4E4_001F_F800);
        send_word(64'hE4E4E4E4_F800_001F);
        send_word(64'h1B1B1B1B_7BEF_7BEF);
        send_word(64'h00000000_0000_0000);
        send_word(64'hFFFFFFFF_FFFF_FFFF);
        send_word(64'hE4E4E4E4_0000_FFFF);
        drain_and_settle();
    endtask

    // DXT3: every nibble value, colour always four-colour
    task automatic test_dxt3_alpha();
        write_format(FMT_DXT3);
        send_word(64'hFEDCBA98_76543210);
        send_word(64'hE4E4E4E4_FFFF_0000);
        send_word(64'hFFFFFFFF_FFFFFFFF);
        send_word(64'h00000000_00000000);
        drain_and_settle();
    endtask

    // DXT5: eight-entry ramp, six-entry ramp, equal endpoints
    task automatic test_dxt5_ramps();
        write_format(FMT_DXT5);
        send_word(64'hFAC688FAC688_00FF);
        send_word(64'hE4E4E4E4_07E0_F81F);
        send_word(64'hFAC688FAC688_FF00);
        send_word(64'h1B6CB1E4_F81F_07E0);
        send_word(64'hFAC688FAC688_8080);
        send_word(64'h00000000_00000000);
        drain_and_settle();
    endtask

    // A format write after a lone alpha word makes the next word alpha again
    task automatic test_phase_restart();
        send_word(64'h0123456789AB_10F0);
        drain_and_settle();
        write_format(FMT_DXT5);
        send_word(64'hFAC688FAC688_40C0);
        send_word(64'hB1E41B6C_0841_F7BE);
        drain_and_settle();
    endtask

    // Unused format code drops words; DXT1 works again afterwards
    task automatic test_format_off();
        write_format(FMT_NONE);
        send_word(64'hE4E4E4E4_001F_F800);
        send_word(64'hFFFFFFFF_FFFFFFFF);
        drain_and_settle();
        write_format(FMT_DXT1);
        send_word(64'h39C639C6_FFE0_001F);
        drain_and_settle();
    endtask

    // Random phases through the three defined formats, mostly well-formed pairs
    task automatic test_random_stream();
        logic [1:0] plan [6];
        int         n;
        plan = '{FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_DXT1, FMT_DXT3};
        for (int p = 0; p < 6; p++) begin
            write_format(plan[p]);
            calm = (p == 3);
            n = 0;
            while (n < 64) begin
                // midway through one phase, hold off until the block has delivered everything
                if (p == 2 && n >= 32 && n < 34)
                    drain_and_settle();
                if (plan[p] == FMT_DXT1 || $urandom_range(0, 9) == 0) begin
                    send_word(rand_word());
                    n += 1;
                end else begin
                    send_word(rand_word());
                    send_word(rand_word());
                    n += 2;
                end
            end
            drain_and_settle();
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_dxt1_palettes();
        test_dxt3_alpha();
        test_dxt5_ramps();
        test_phase_restart();
        test_format_off();
        test_random_stream();
        drain_and_settle();
        if (mismatches == 0)
            $display("dxt_block_decoder_core: match");
        else
            $display("dxt_block_decoder_core: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("dxt_block_decoder_core: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dxt_pkg.sv
rtl/dxt_interp.sv
rtl/dxt_block_decoder_core.sv
tb/dxt_block_decoder_core_tb.sv
